>>> hw/rtl/sorted_circular_priority_table_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted circular priority table
// Concurrent checks on clk_i / rst_ni, compiled away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_CIRCULAR_PRIORITY_TABLE_UNIT_DEFINES_SVH
`define SORTED_CIRCULAR_PRIORITY_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define SCPT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("table check failed");
// cond must never be seen outside reset
`define SCPT_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden table condition");
`else
`define SCPT_ASSERT(label, prop)
`define SCPT_ASSERT_NEVER(label, cond)
`endif

`endif

>>> hw/rtl/scpt_pkg.sv
// ----------------------------------------------------------------------------
// scpt_pkg
// Types and codes shared by the sorted circular priority table.
// ----------------------------------------------------------------------------
`default_nettype none

package scpt_pkg;

  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_COUNT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_NONE    = 2'd3
  } status_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] key;
    logic               kind;
    logic [7:0]         tag;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] found_position;
    logic [7:0] found_tag;
    logic [4:0] kind_count;
    logic [4:0] occupancy;
  } rsp_t;

  // one table slot as stored in memory
  typedef struct packed {
    logic signed [15:0] key;
    logic               kind;
    logic [7:0]         tag;
  } entry_t;

endpackage

`default_nettype wire

>>> hw/rtl/scpt_ram.sv
// ----------------------------------------------------------------------------
// scpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module scpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_circular_priority_table_unit.sv
// A rejected request (full, bad position) or an insert/count on an empty table
//   is answered from idle without a walk through the entry RAM.
// Throughput: one transaction at a time; busy stays high while the walk runs,
//   one table entry per cycle through the single read port of the entry RAM.
// Reset clears the entry count and control only; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_circular_priority_table_unit
// Key-ordered ring of entries with stable insert, remove, find-other-kind
// and kind count, all entries held in one entry RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_circular_priority_table_unit_defines.svh"

module sorted_circular_priority_table_unit #(
  parameter int unsigned DEPTH = scpt_pkg::DefaultDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire scpt_pkg::req_t req_i,
  output logic               done_o,
  output scpt_pkg::rsp_t     rsp_o
);

  import scpt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > 4) ? CW : 4;
  localparam int unsigned EW = $bits(entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] total_q, total_d;
  logic          done_q, done_d;
  logic          first_q, first_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] step_q, step_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          own_q, own_d;
  logic [7:0]    gone_q, gone_d;
  req_t          req_q, req_d;
  rsp_t          rsp_q, rsp_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  entry_t        rd_entry;
  entry_t        new_entry;
  logic [CW-1:0] idx_w, idx_nx_w, cnt_nx;
  logic [AW-1:0] idx_wrap;
  logic          pos_ok;

  scpt_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign idx_w    = CW'(idx_q);
  assign idx_nx_w = idx_w + CW'(1);
  assign idx_wrap = (idx_nx_w == total_q) ? '0 : AW'(idx_nx_w);
  assign cnt_nx   = cnt_q + CW'(rd_entry.kind == req_q.kind);
  assign pos_ok   = PW'(req_i.position) < PW'(total_q);

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    done_d    = 1'b0;
    first_d   = first_q;
    idx_d     = idx_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    own_d     = own_q;
    gone_d    = gone_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx_q;
    ram_raddr = idx_q;
    new_entry = '{key: req_q.key, kind: req_q.kind, tag: req_q.tag};
    ram_wdata = EW'(new_entry);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d     = req_i;
          first_d   = 1'b1;
          cnt_d     = '0;
          new_entry = '{key: req_i.key, kind: req_i.kind, tag: req_i.tag};
          ram_wdata = EW'(new_entry);
          case (req_i.op)
            OP_INSERT: begin
              if (total_q == CW'(DEPTH)) begin
                done_d     = 1'b1;
                rsp_d      = '0;
                rsp_d.status = ST_FULL;
              end else if (total_q == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                total_d   = CW'(1);
                done_d    = 1'b1;
                rsp_d     = '0;
                rsp_d.status    = ST_OK;
                rsp_d.found_tag = req_i.tag;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(total_q - CW'(1));
                idx_d     = AW'(total_q - CW'(1));
                state_d   = S_SCAN;
              end
            end
            OP_REMOVE, OP_FIND: begin
              if (!pos_ok) begin
                done_d       = 1'b1;
                rsp_d        = '0;
                rsp_d.status = ST_INVALID;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(req_i.position);
                idx_d     = AW'(req_i.position);
                state_d   = S_SCAN;
              end
            end
            OP_COUNT: begin
              if (total_q == '0) begin
                done_d       = 1'b1;
                rsp_d        = '0;
                rsp_d.status = ST_OK;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = S_SCAN;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        case (req_q.op)
          OP_INSERT: begin
            // walk down from the tail, moving larger keys one slot up
            ram_we    = 1'b1;
            ram_waddr = AW'(idx_nx_w);
            if ($signed(rd_entry.key) > $signed(req_q.key)) begin
              ram_wdata = EW'(rd_entry);
              if (idx_q == '0) begin
                state_d = S_PUT;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = idx_q - AW'(1);
                idx_d     = idx_q - AW'(1);
              end
            end else begin
              total_d = total_q + CW'(1);
              done_d  = 1'b1;
              rsp_d   = '0;
              rsp_d.status         = ST_OK;
              rsp_d.found_position = 4'(idx_nx_w);
              rsp_d.found_tag      = req_q.tag;
              state_d = S_IDLE;
            end
          end
          OP_REMOVE: begin
            if (!first_q) begin
              ram_we    = 1'b1;
              ram_waddr = idx_q - AW'(1);
              ram_wdata = EW'(rd_entry);
            end
            if (first_q) begin
              gone_d  = rd_entry.tag;
              first_d = 1'b0;
            end
            if (idx_nx_w < total_q) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(idx_nx_w);
              idx_d     = AW'(idx_nx_w);
            end else begin
              total_d = total_q - CW'(1);
              done_d  = 1'b1;
              rsp_d   = '0;
              rsp_d.status         = ST_OK;
              rsp_d.found_position = req_q.position;
              rsp_d.found_tag      = first_q ? rd_entry.tag : gone_q;
              state_d = S_IDLE;
            end
          end
          OP_FIND: begin
            if (first_q) begin
              own_d   = rd_entry.kind;
              first_d = 1'b0;
              if (total_q == CW'(1)) begin
                done_d       = 1'b1;
                rsp_d        = '0;
                rsp_d.status = ST_NONE;
                state_d      = S_IDLE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = idx_wrap;
                idx_d     = idx_wrap;
                step_d    = CW'(1);
              end
            end else if (rd_entry.kind != own_q) begin
              done_d = 1'b1;
              rsp_d  = '0;
              rsp_d.status         = ST_OK;
              rsp_d.found_position = 4'(idx_q);
              rsp_d.found_tag      = rd_entry.tag;
              state_d = S_IDLE;
            end else if (step_q == total_q - CW'(1)) begin
              done_d       = 1'b1;
              rsp_d        = '0;
              rsp_d.status = ST_NONE;
              state_d      = S_IDLE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = idx_wrap;
              idx_d     = idx_wrap;
              step_d    = step_q + CW'(1);
            end
          end
          OP_COUNT: begin
            if (idx_nx_w == total_q) begin
              done_d = 1'b1;
              rsp_d  = '0;
              rsp_d.status     = ST_OK;
              rsp_d.kind_count = 5'(cnt_nx);
              state_d = S_IDLE;
            end else begin
              cnt_d     = cnt_nx;
              ram_re    = 1'b1;
              ram_raddr = AW'(idx_nx_w);
              idx_d     = AW'(idx_nx_w);
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_PUT: begin
        // new entry goes to the head
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        total_d   = total_q + CW'(1);
        done_d    = 1'b1;
        rsp_d     = '0;
        rsp_d.status         = ST_OK;
        rsp_d.found_position = 4'(idx_q);
        rsp_d.found_tag      = req_q.tag;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done_d) begin
      rsp_d.occupancy = 5'(total_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      done_q  <= done_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    step_q <= step_d;
    cnt_q  <= cnt_d;
    own_q  <= own_d;
    gone_q <= gone_d;
    req_q  <= req_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `SCPT_ASSERT(a_total_bound, total_q <= CW'(DEPTH))
  `SCPT_ASSERT(a_busy_ends_with_result, $fell(busy) |-> done_o)
  `SCPT_ASSERT(a_full_only_at_depth, (done_o && rsp_o.status == ST_FULL) |-> total_q == CW'(DEPTH))
  `SCPT_ASSERT_NEVER(a_no_ram_overlap, ram_we && ram_re && (ram_waddr == ram_raddr))

endmodule

`default_nettype wire
